>>> rtl/core/hpq_pkg.sv
package hpq_pkg;

   localparam int DEF_CAPACITY = 128;
   localparam int KEY_W        = 16;
   localparam int TAG_W        = 16;
   localparam int COUNT_OUT_W  = 8;
   localparam int STATUS_W     = 2;

   localparam logic signed [KEY_W-1:0] THRESHOLD_RESET = 16'sd2;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // command sequencer
   typedef enum logic [1:0] {
      CMD_IDLE,
      CMD_SIFT,
      CMD_RESP
   } cmd_state_type;

   // sift-up engine
   typedef enum logic [1:0] {
      SIFT_IDLE,
      SIFT_SEEK,
      SIFT_CMP
   } sift_state_type;

   // sift engine back to the command sequencer
   typedef struct packed {
      logic                    done;
      logic signed [KEY_W-1:0] root_key;
      logic [TAG_W-1:0]        root_tag;
   } sift_status_type;

endpackage

>>> rtl/core/hpq_ram.sv
module hpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hpq_sift.sv
module hpq_sift #(
   parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic signed [hpq_pkg::KEY_W-1:0]     go_key,
   input  logic [hpq_pkg::TAG_W-1:0]            go_tag,
   input  logic [$clog2(CAPACITY)-1:0]          go_pos,
   output hpq_pkg::sift_status_type             sts
);

   import hpq_pkg::*;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int ENTRY_W = KEY_W + TAG_W;

   sift_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic signed [KEY_W-1:0] key_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic signed [KEY_W-1:0] root_key_ff;
   logic [TAG_W-1:0]        root_tag_ff;

   logic [ADDR_W-1:0]       par_addr;
   logic [ADDR_W-1:0]       gpar_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]      wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   logic signed [KEY_W-1:0] rd_key;
   logic                    swap;
   logic                    done;
   logic                    root_wr;

   // walk up the path: parent and grandparent of the hole
   assign par_addr  = ADDR_W'(pos_ff - 1'b1) >> 1;
   assign gpar_addr = ADDR_W'(par_addr - 1'b1) >> 1;

   // shared compare unit
   assign rd_key = rd_data[ENTRY_W-1 -: KEY_W];
   assign swap   = rd_key > key_ff;

   hpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         SIFT_IDLE: begin
            if (go) begin
               state_in = SIFT_SEEK;
               pos_in   = go_pos;
            end
         end
         SIFT_SEEK: begin
            if (pos_ff == '0) begin
               state_in = SIFT_IDLE;
            end else begin
               state_in = SIFT_CMP;
            end
         end
         SIFT_CMP: begin
            if (swap) begin
               pos_in = par_addr;
               if (par_addr == '0) begin
                  state_in = SIFT_SEEK;
               end
            end else begin
               state_in = SIFT_IDLE;
            end
         end
         default: state_in = SIFT_IDLE;
      endcase
   end

   // outputs: ram port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {key_ff, tag_ff};
      rd_en   = 1'b0;
      rd_addr = par_addr;
      done    = 1'b0;
      root_wr = 1'b0;
      case (state_ff)
         SIFT_SEEK: begin
            if (pos_ff == '0) begin
               wr_en   = 1'b1;
               done    = 1'b1;
               root_wr = 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         SIFT_CMP: begin
            wr_en = 1'b1;
            if (swap) begin
               // parent moves down into the hole, fetch the next parent
               wr_data = rd_data;
               rd_en   = 1'b1;
               rd_addr = gpar_addr;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIFT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (state_ff == SIFT_IDLE && go) begin
         key_ff <= go_key;
         tag_ff <= go_tag;
      end
      if (root_wr) begin
         root_key_ff <= key_ff;
         root_tag_ff <= tag_ff;
      end
   end

   assign sts.done     = done;
   assign sts.root_key = root_key_ff;
   assign sts.root_tag = root_tag_ff;

`ifndef SYNTH
   a_cmp_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == SIFT_CMP |-> pos_ff != '0)
      else $error("sift compare with the hole at the root");
`endif

endmodule

>>> rtl/core/min_heap_priority_queue.sv
// Binary min-heap priority queue of signed 16-bit keys, each with a 16-bit tag.
// A transaction is taken when start is high and busy is low; req_action 0
// inserts req_priority_key/req_entry_tag, 1 peeks. Every transaction gives
// exactly one result, shown for a single cycle with rsp_strobe high; the
// receiver cannot stall, so it must capture the result in that cycle. An
// insert appends the entry and sifts it up with one compare per level through
// a single-port-write, registered-read entry memory. An insert into a full
// heap is dropped and reported with status 2. Results carry the current
// minimum, the entry count and an alert when the minimum is at or below the
// threshold written on the csr_ port (reset value 2, always ready).
module min_heap_priority_queue #(
   parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // transaction request
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_action,
   input  logic signed [hpq_pkg::KEY_W-1:0]       req_priority_key,
   input  logic [hpq_pkg::TAG_W-1:0]              req_entry_tag,
   // result
   output logic                                   rsp_strobe,
   output logic [hpq_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [hpq_pkg::KEY_W-1:0]       rsp_top_key,
   output logic [hpq_pkg::TAG_W-1:0]              rsp_top_tag,
   output logic                                   rsp_alert,
   output logic [hpq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   // threshold register
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic signed [hpq_pkg::KEY_W-1:0]       csr_alert_threshold
);

   import hpq_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   cmd_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              status_ff, status_in;
   logic signed [KEY_W-1:0] thr_ff;

   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    sift_go;
   sift_status_type         sift_sts;

   assign accept = start && !busy;
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign empty  = count_ff == '0;
   // an insert that fits kicks off the sift engine
   assign sift_go = accept && !req_action && !full;

   hpq_sift #(
      .CAPACITY (CAPACITY)
   ) u_sift (
      .clock  (clock),
      .reset  (reset),
      .go     (sift_go),
      .go_key (req_priority_key),
      .go_tag (req_entry_tag),
      .go_pos (count_ff[ADDR_W-1:0]),
      .sts    (sift_sts)
   );

   // next state, count and status
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         CMD_IDLE: begin
            if (accept) begin
               if (!req_action) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                     state_in  = CMD_RESP;
                  end else begin
                     status_in = STATUS_OK;
                     state_in  = CMD_SIFT;
                  end
               end else begin
                  status_in = empty ? STATUS_EMPTY : STATUS_OK;
                  state_in  = CMD_RESP;
               end
            end
         end
         CMD_SIFT: begin
            // entry is in place once the engine reports done
            if (sift_sts.done) begin
               count_in = count_ff + 1'b1;
               state_in = CMD_RESP;
            end
         end
         CMD_RESP: state_in = CMD_IDLE;
         default:  state_in = CMD_IDLE;
      endcase
   end

   // result and handshake outputs
   always_comb begin
      busy            = state_ff != CMD_IDLE;
      rsp_strobe      = state_ff == CMD_RESP;
      rsp_status      = status_ff;
      rsp_entry_count = COUNT_OUT_W'(count_ff);
      if (empty) begin
         // nothing held: report zeros
         rsp_top_key = '0;
         rsp_top_tag = '0;
         rsp_alert   = 1'b0;
      end else begin
         rsp_top_key = sift_sts.root_key;
         rsp_top_tag = sift_sts.root_tag;
         rsp_alert   = sift_sts.root_key <= thr_ff;
      end
   end

   // threshold register is always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CMD_IDLE;
         count_ff  <= '0;
         status_ff <= STATUS_OK;
         thr_ff    <= THRESHOLD_RESET;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_alert_threshold;
         end
      end
   end

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after taking a transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == CMD_SIFT && rsp_strobe)
      else $error("entry count moved outside a completed insert");
`endif

endmodule
